// ===== design/mma_pkg.sv =====
// shared types and constants of the multichannel moving average
package mma_pkg;

  // fixed field widths
  localparam int CH_FIELD_W = 5;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_W      = 11;
  localparam int HELD_W     = 11;
  localparam int SUM_W      = 26;

  // ring size per channel, tied to the held and sum widths above
  localparam int WINDOW_MAX = 1024;

  // register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register reset values
  localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 11'd1024;
  localparam logic [CFG_W-1:0] MIN_FILL_RST   = 11'd1024;

  // register indexes, decoded from the word address
  typedef enum logic [0:0] {
    REG_WINDOW_LEN = 1'b0,
    REG_MIN_FILL   = 1'b1
  } reg_idx_e;

  // configuration seen by the datapath
  typedef struct packed {
    logic [CFG_W-1:0] win_eff;
    logic [CFG_W-1:0] min_fill;
    logic             win_wr;
  } mma_cfg_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } mma_div_stat_t;

endpackage

// ===== design/mma_if.sv =====
// valid/ready channels for sample input and average output

interface mma_in_if import mma_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CH_FIELD_W-1:0] channel;
  logic [SAMPLE_W-1:0]   sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mma_out_if import mma_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CH_FIELD_W-1:0] out_channel;
  logic [SAMPLE_W-1:0]   average;
  logic                  ready_res;
  logic [HELD_W-1:0]     held;
  logic                  evicted;

  modport source (output valid, output out_channel, output average, output ready_res,
                  output held, output evicted, input ready);
  modport sink   (input valid, input out_channel, input average, input ready_res,
                  input held, input evicted, output ready);
endinterface

// ===== design/multichannel_moving_average_core.sv =====
// top level: per-channel moving average with sample rings and serial divider
//
// Each input beat names a channel and brings a 16-bit sample; each beat on a channel
// below NUM_CHANNELS gives one output beat with the truncated mean of that channel's
// last window_len samples, the count held, a ready flag (held >= min_fill) and an
// eviction flag. Beats naming a higher channel are dropped with no output. Items are
// handled one at a time: the channel state is read, the ring slot is read and overwritten,
// the sum is updated, the bit-serial divider forms the 26-bit quotient, the sequencer sees
// the divider finish, and the output register is loaded once it is free. The input is
// taken again the cycle after a result is loaded into the output register, even while
// that result waits to be taken, so no new beat is taken while an item is in work. Writing
// window_len empties all channel windows at once; no clearing pass is needed after reset.
module multichannel_moving_average_core import mma_pkg::*; #(
  parameter int NUM_CHANNELS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mma_in_if.sink            in_i,
  mma_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CH_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int POS_W       = $clog2(WINDOW_MAX);
  localparam int STORE_DEPTH = NUM_CHANNELS * WINDOW_MAX;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [POS_W-1:0]  pos;
    logic [HELD_W-1:0] fill;
  } chan_st_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STORE,
    ST_UPD,
    ST_DIV,
    ST_OUT
  } state_e;

  mma_cfg_t      cfg;
  mma_div_stat_t div_stat;
  state_e        state_q;

  // item registers
  logic [CH_FIELD_W-1:0] ch_q;
  logic [SAMPLE_W-1:0]   smp_q;
  logic [SUM_W-1:0]      sum_q;
  logic [POS_W-1:0]      pos_q;
  logic [HELD_W-1:0]     held_q;
  logic                  evict_q;
  logic [ADDR_W-1:0]     addr_q;

  // memories and valid bits
  chan_st_t              chan_mem [NUM_CHANNELS];
  chan_st_t              chan_rd_q;
  logic [SAMPLE_W-1:0]   store_mem [STORE_DEPTH];
  logic [SAMPLE_W-1:0]   store_rd_q;
  logic [NUM_CHANNELS-1:0] valid_q;

  // output register
  logic                  out_valid_q;
  logic [CH_FIELD_W-1:0] out_ch_q;
  logic [SAMPLE_W-1:0]   out_avg_q;
  logic                  out_rdy_res_q;
  logic [HELD_W-1:0]     out_held_q;
  logic                  out_evict_q;

  logic [CH_W-1:0]   in_idx;
  logic [CH_W-1:0]   ch_idx;
  logic              in_range;
  logic              accept;
  logic              out_free;
  chan_st_t          chan_cur;
  logic [POS_W-1:0]  pos_cur;
  logic [HELD_W-1:0] held_cur;
  logic [SUM_W-1:0]  sum_new;
  logic [HELD_W-1:0] held_new;
  logic [POS_W:0]    pos_inc;
  logic [POS_W-1:0]  pos_new;
  chan_st_t          chan_new;
  logic              div_start;
  logic [SUM_W-1:0]  quotient;

  mma_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  assign pready = 1'b1;

  // input handshake
  assign in_idx   = CH_W'(in_i.channel);
  assign ch_idx   = CH_W'(ch_q);
  assign in_range = 32'(in_i.channel) < 32'(NUM_CHANNELS);
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // channel state as read, with an empty window where its valid bit is clear
  always_comb begin
    chan_cur = valid_q[ch_idx] ? chan_rd_q : '0;
    pos_cur  = (32'(chan_cur.pos) >= 32'(cfg.win_eff)) ? '0 : chan_cur.pos;
    held_cur = (chan_cur.fill > cfg.win_eff) ? cfg.win_eff : chan_cur.fill;
  end

  // update of sum, count and ring position
  always_comb begin
    sum_new  = evict_q ? (sum_q - SUM_W'(store_rd_q)) : sum_q;
    held_new = evict_q ? held_q : (held_q + 1'b1);
    pos_inc  = {1'b0, pos_q} + 1'b1;
    pos_new  = (32'(pos_inc) >= 32'(cfg.win_eff)) ? '0 : pos_inc[POS_W-1:0];
    chan_new = '{sum: sum_new, pos: pos_new, fill: held_new};
  end

  assign div_start = (state_q == ST_UPD);

  mma_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_new),
    .divisor_i  (held_new),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      priority if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE:  if (accept && in_range) state_q <= ST_LOAD;
        ST_LOAD:  state_q <= ST_STORE;
        ST_STORE: state_q <= ST_UPD;
        ST_UPD:   state_q <= ST_DIV;
        ST_DIV:   if (div_stat.done) state_q <= ST_OUT;
        ST_OUT:   if (out_free) state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  // channel valid bits, all cleared when window_len is written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cfg.win_wr) begin
      valid_q <= '0;
    end else if (state_q == ST_UPD) begin
      valid_q[ch_idx] <= 1'b1;
    end
  end

  // per-channel state memory
  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD) begin
      chan_mem[ch_idx] <= chan_new;
    end
    if (accept) begin
      chan_rd_q <= chan_mem[in_idx];
    end
  end

  // sample rings: read the oldest slot and overwrite it in the same cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ST_STORE) begin
      store_rd_q       <= store_mem[addr_q];
      store_mem[addr_q] <= smp_q;
    end
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ch_q  <= in_i.channel;
          smp_q <= in_i.sample;
        end
      end
      ST_LOAD: begin
        sum_q   <= chan_cur.sum;
        pos_q   <= pos_cur;
        held_q  <= held_cur;
        evict_q <= (held_cur >= cfg.win_eff);
        addr_q  <= ADDR_W'(32'(ch_idx) * 32'(WINDOW_MAX) + 32'(pos_cur));
      end
      ST_STORE: sum_q <= sum_q + SUM_W'(smp_q);
      ST_UPD:   held_q <= held_new;
      default:  ;
    endcase
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      out_ch_q      <= ch_q;
      out_avg_q     <= quotient[SAMPLE_W-1:0];
      out_rdy_res_q <= (held_q >= cfg.min_fill);
      out_held_q    <= held_q;
      out_evict_q   <= evict_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_channel = out_ch_q;
  assign out_o.average     = out_avg_q;
  assign out_o.ready_res   = out_rdy_res_q;
  assign out_o.held        = out_held_q;
  assign out_o.evicted     = out_evict_q;

  // held count stays inside the window
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.held != '0 && out_o.held <= cfg.win_eff))
    else $error("held count outside window");

  // an eviction only happens with a full window
  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.evicted) |-> (out_o.held == cfg.win_eff))
    else $error("eviction with window not full");

  // the divider is never restarted while it runs
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // an in-range beat blocks the input until its result is loaded
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_range) |=> !in_i.ready)
    else $error("input taken while an item is in work");

endmodule

// ===== design/mma_cfg_regs.sv =====
// configuration registers behind the apb-style port
module mma_cfg_regs import mma_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  output logic [APB_DW-1:0] prdata_o,
  output mma_cfg_t          cfg_o
);

  logic [CFG_W-1:0] window_q;
  logic [CFG_W-1:0] min_fill_q;
  logic             wr;
  reg_idx_e         sel;

  // word select and write strobe
  assign sel = reg_idx_e'(paddr_i[2]);
  assign wr  = psel_i && penable_i && pwrite_i;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= WINDOW_LEN_RST;
      min_fill_q <= MIN_FILL_RST;
    end else if (wr) begin
      unique case (sel)
        REG_WINDOW_LEN: window_q   <= pwdata_i[CFG_W-1:0];
        REG_MIN_FILL:   min_fill_q <= pwdata_i[CFG_W-1:0];
        default:        ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (sel)
      REG_WINDOW_LEN: prdata_o = {{(APB_DW-CFG_W){1'b0}}, window_q};
      REG_MIN_FILL:   prdata_o = {{(APB_DW-CFG_W){1'b0}}, min_fill_q};
      default:        prdata_o = '0;
    endcase
  end

  // effective window: zero means one, saturate at the ring size
  always_comb begin
    priority if (window_q == '0) begin
      cfg_o.win_eff = CFG_W'(1);
    end else if (32'(window_q) > 32'(WINDOW_MAX)) begin
      cfg_o.win_eff = CFG_W'(WINDOW_MAX);
    end else begin
      cfg_o.win_eff = window_q;
    end
  end

  assign cfg_o.min_fill = min_fill_q;
  assign cfg_o.win_wr   = wr && (sel == REG_WINDOW_LEN);

endmodule

// ===== design/mma_serial_div.sv =====
// restoring divider, one quotient bit per cycle through a shift register
module mma_serial_div import mma_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  dividend_i,
  input  logic [HELD_W-1:0] divisor_i,
  output logic [SUM_W-1:0]  quotient_o,
  output mma_div_stat_t     stat_o
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_e;

  div_state_e        state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;
  logic [SUM_W-1:0]  dvd_q;
  logic [HELD_W-1:0] rem_q;
  logic [HELD_W-1:0] dsr_q;
  logic [HELD_W:0]   shifted;
  logic [HELD_W:0]   diff;
  logic              fits;

  // one trial subtraction per cycle
  assign shifted = {rem_q, dvd_q[SUM_W-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign fits    = shifted >= {1'b0, dsr_q};

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        DIV_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            state_q <= DIV_RUN;
            cnt_q   <= '0;
          end
        end
        DIV_RUN: begin
          cnt_q  <= cnt_q + 1'b1;
          done_q <= (cnt_q == CNT_W'(SUM_W - 1));
          if (cnt_q == CNT_W'(SUM_W - 1)) begin
            state_q <= DIV_IDLE;
          end
        end
        default: begin
          state_q <= DIV_IDLE;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  // dividend shifts out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (state_q == DIV_RUN) begin
      dvd_q <= {dvd_q[SUM_W-2:0], fits};
      rem_q <= fits ? diff[HELD_W-1:0] : shifted[HELD_W-1:0];
    end
  end

  assign quotient_o  = dvd_q;
  assign stat_o.busy = (state_q == DIV_RUN);
  assign stat_o.done = done_q;

endmodule
